[design/rar_pkg.sv]
`timescale 1ns / 1ps
package rar_pkg;
  localparam int WIDTH = 32;
  localparam int MW = 2 * WIDTH + 1;
  localparam int CW = $clog2(MW + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  typedef logic [MW-1:0] mag_t;

  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quot;
    mag_t rem;
  } div_rsp_t;
endpackage

[design/rational_arith_reduce.sv]
`timescale 1ns / 1ps
// rational_arith_reduce: combines two signed fractions by add, subtract,
// multiply or divide and reduces the result by the gcd of its terms.
// s_axis: one beat per request, tdata carries req_type, a_num, a_den,
// b_num, b_den. m_axis: one beat per result, tdata carries res_num,
// res_den and status.
// only one request is in flight: s_axis_tready is low from acceptance
// until the result beat has been taken downstream.
// the cross products are formed in states MUL1 to MUL4 and COMB, then
// one shared restoring divider runs Euclid's remainder steps, their number
// data dependent, followed by two divisions by the gcd; zero over zero
// is flagged undefined without using the divider.
// a stalled receiver holds the result in the output register and the
// block takes no new beat until it is taken.
// reset returns the sequencer to idle and drops any request in progress.
module rational_arith_reduce (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[63:32], status[65:64]
  output logic [71:0]  m_axis_tdata
);
  import rar_pkg::*;

  typedef enum logic [3:0] {
    IDLE, MUL1, MUL2, MUL3, MUL4, COMB, GCD_CHK, GCD_WAIT,
    DIVN, DIVN_WAIT, DIVD, DIVD_WAIT, FIN, OUT
  } state_t;

  state_t state;
  logic [1:0] op;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] ma, mb;
  logic [2*WIDTH-1:0] prod;
  logic [2*WIDTH-1:0] p1, p2;
  logic s1, s2;
  mag_t n_mag, d_mag, x, y, g;
  logic n_neg, d_neg;
  logic swap;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [1:0] st;
  logic [WIDTH-1:0] rn, rd;

  function automatic logic [WIDTH:0] take(input logic [31:0] raw);
    logic [WIDTH-1:0] v;
    begin
      v = raw[WIDTH-1:0];
      take = v[WIDTH-1] ? {1'b1, WIDTH'(~v + 1'b1)} : {1'b0, v};
    end
  endfunction

  function automatic logic fits(input mag_t m, input logic neg);
    begin
      if (neg) fits = m <= (mag_t'(1) << (WIDTH - 1));
      else fits = m < (mag_t'(1) << (WIDTH - 1));
    end
  endfunction

  always_comb begin
    ma = an_m;
    mb = bd_m;
    case (state)
      MUL1: begin ma = an_m; mb = (op == OP_MUL) ? bn_m : bd_m; end
      MUL2: begin ma = bn_m; mb = ad_m; end
      MUL3: begin ma = ad_m; mb = (op == OP_DIV) ? bn_m : bd_m; end
      default: begin ma = an_m; mb = bd_m; end
    endcase
  end

  rar_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign s_axis_tready = (state == IDLE);
  assign m_axis_tvalid = (state == OUT);
  assign m_axis_tdata = {6'd0, st, 32'(signed'(rd)), 32'(signed'(rn))};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      prod <= ma * mb;
      case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            op <= s_axis_tdata[1:0];
            {an_s, an_m} <= take(s_axis_tdata[33:2]);
            {ad_s, ad_m} <= take(s_axis_tdata[65:34]);
            {bn_s, bn_m} <= take(s_axis_tdata[97:66]);
            {bd_s, bd_m} <= take(s_axis_tdata[129:98]);
            state <= MUL1;
          end
        end
        MUL1: state <= MUL2;
        MUL2: begin
          p1 <= prod;
          s1 <= an_s ^ ((op == OP_MUL) ? bn_s : bd_s);
          state <= MUL3;
        end
        MUL3: begin
          p2 <= prod;
          s2 <= (bn_s ^ ad_s) ^ (op == OP_SUB);
          state <= MUL4;
        end
        MUL4: begin
          d_mag <= mag_t'(prod);
          d_neg <= (prod != '0) && (ad_s ^ ((op == OP_DIV) ? bn_s : bd_s));
          state <= COMB;
        end
        COMB: begin
          if (op == OP_MUL || op == OP_DIV) begin
            n_mag <= mag_t'(p1);
            n_neg <= (p1 != '0) && s1;
          end else if (s1 == s2) begin
            n_mag <= mag_t'(p1) + mag_t'(p2);
            n_neg <= ((p1 != '0) || (p2 != '0)) && s1;
          end else if (p1 >= p2) begin
            n_mag <= mag_t'(p1 - p2);
            n_neg <= (p1 != p2) && s1;
          end else begin
            n_mag <= mag_t'(p2 - p1);
            n_neg <= s2;
          end
          state <= GCD_CHK;
        end
        GCD_CHK: begin
          if (state == GCD_CHK && x == '0 && y == '0 && n_mag == '0 && d_mag == '0) begin
            st <= ST_UNDEF; rn <= '0; rd <= '0; state <= OUT;
          end else if (x == '0 || y == '0) begin
            g <= x | y;
            state <= DIVN;
          end else begin
            swap <= x > y;
            dreq.dividend <= (x > y) ? x : y;
            dreq.divisor <= (x > y) ? y : x;
            dreq.start <= 1'b1;
            state <= GCD_WAIT;
          end
        end
        GCD_WAIT: begin
          if (drsp.done) begin
            if (swap) x <= drsp.rem;
            else y <= drsp.rem;
            state <= GCD_CHK;
          end
        end
        DIVN: begin
          dreq.dividend <= n_mag; dreq.divisor <= g; dreq.start <= 1'b1;
          state <= DIVN_WAIT;
        end
        DIVN_WAIT: if (drsp.done) begin n_mag <= drsp.quot; state <= DIVD; end
        DIVD: begin
          dreq.dividend <= d_mag; dreq.divisor <= g; dreq.start <= 1'b1;
          state <= DIVD_WAIT;
        end
        DIVD_WAIT: if (drsp.done) begin d_mag <= drsp.quot; state <= FIN; end
        FIN: begin
          if (!fits(n_mag, n_neg) || !fits(d_mag, d_neg)) begin
            st <= ST_OVF; rn <= '0; rd <= '0;
          end else begin
            st <= ST_OK;
            rn <= n_neg ? WIDTH'(~n_mag + 1'b1) : WIDTH'(n_mag);
            rd <= d_neg ? WIDTH'(~d_mag + 1'b1) : WIDTH'(d_mag);
          end
          state <= OUT;
        end
        OUT: if (m_axis_tready) state <= IDLE;
        default: state <= IDLE;
      endcase
      if (state == COMB) begin
        x <= (op == OP_MUL || op == OP_DIV) ? mag_t'(p1)
           : (s1 == s2) ? mag_t'(p1) + mag_t'(p2)
           : (p1 >= p2) ? mag_t'(p1 - p2) : mag_t'(p2 - p1);
        y <= d_mag;
      end
    end
  end
endmodule

[design/rar_div.sv]
`timescale 1ns / 1ps
module rar_div (
  input  logic              clk,
  input  logic              rst,
  input  rar_pkg::div_req_t req,
  output rar_pkg::div_rsp_t rsp
);
  import rar_pkg::*;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  mag_t          q;
  mag_t          r;
  mag_t          dv;
  logic [MW:0]   trial;

  // restoring division, one quotient bit per cycle
  assign trial = {r, q[MW-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CW'(MW);
        q <= req.dividend;
        r <= '0;
        dv <= req.divisor;
      end else if (busy) begin
        if (trial[MW]) begin
          r <= {r[MW-2:0], q[MW-1]};
          q <= {q[MW-2:0], 1'b0};
        end else begin
          r <= trial[MW-1:0];
          q <= {q[MW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, q, r};
endmodule

[design/rar_checker.sv]
`timescale 1ns / 1ps
module rar_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_one: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input open while result pending");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not busy after accept");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[65:64] != 2'd0 |-> m_axis_tdata[63:0] == '0)
    else $error("error status with nonzero terms");
endmodule

bind rational_arith_reduce rar_checker u_chk (.*);

[test/rar_checker.sv]
`timescale 1ns / 1ps
module tb_rar_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending
);
  import rar_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] den;
    logic [31:0] num;
  } fraction_t;

  typedef struct {
    logic        neg;
    logic [64:0] mag;
  } smag_s;

  fraction_t expected_q[$];

  function automatic smag_s to_smag(logic [31:0] raw);
    smag_s r;
    logic [WIDTH-1:0] x;
    x = raw[WIDTH-1:0];
    r.neg = x[WIDTH-1];
    r.mag = r.neg ? 65'(-x) & ((65'd1 << WIDTH) - 1) : 65'(x);
    if (r.neg && r.mag == 0) r.mag = 65'd1 << WIDTH;
    return r;
  endfunction

  function automatic smag_s smul(smag_s a, smag_s b);
    smag_s r;
    r.mag = a.mag * b.mag;
    r.neg = (r.mag != 0) && (a.neg != b.neg);
    return r;
  endfunction

  function automatic smag_s sadd(smag_s a, smag_s b);
    smag_s r;
    if (a.neg == b.neg) begin
      r.mag = a.mag + b.mag;
      r.neg = a.neg;
    end else if (a.mag >= b.mag) begin
      r.mag = a.mag - b.mag;
      r.neg = a.neg;
    end else begin
      r.mag = b.mag - a.mag;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic in_range(smag_s v);
    logic [64:0] lim;
    lim = 65'd1 << (WIDTH - 1);
    return v.neg ? (v.mag <= lim) : (v.mag < lim);
  endfunction

  function automatic fraction_t reduce_fraction(logic [135:0] d);
    smag_s an, ad, bn, bd, n, d2, t;
    logic [64:0] x, y, g;
    fraction_t r;
    an = to_smag(d[33:2]);
    ad = to_smag(d[65:34]);
    bn = to_smag(d[97:66]);
    bd = to_smag(d[129:98]);
    case (d[1:0])
      OP_ADD: begin
        n = sadd(smul(an, bd), smul(bn, ad));
        d2 = smul(ad, bd);
      end
      OP_SUB: begin
        t = smul(bn, ad);
        t.neg = (t.mag != 0) && !t.neg;
        n = sadd(smul(an, bd), t);
        d2 = smul(ad, bd);
      end
      OP_MUL: begin
        n = smul(an, bn);
        d2 = smul(ad, bd);
      end
      default: begin
        n = smul(an, bd);
        d2 = smul(ad, bn);
      end
    endcase
    x = n.mag;
    y = d2.mag;
    while (x > 0 && y > 0) begin
      if (x > y) x = x % y;
      else y = y % x;
    end
    g = x + y;
    r = '0;
    if (g == 0) begin
      r.status = ST_UNDEF;
      return r;
    end
    n.mag = n.mag / g;
    d2.mag = d2.mag / g;
    if (!in_range(n) || !in_range(d2)) begin
      r.status = ST_OVF;
      return r;
    end
    r.status = ST_OK;
    r.num = n.neg ? 32'(-n.mag) : 32'(n.mag);
    r.den = d2.neg ? 32'(-d2.mag) : 32'(d2.mag);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    fraction_t want, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(reduce_fraction(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[65:0];
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected beat %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got.num !== want.num || got.den !== want.den
              || got.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d",
                $signed(want.num), $signed(want.den), want.status,
                $signed(got.num), $signed(got.den), got.status);
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

[test/tb_rational_arith_reduce.sv]
`timescale 1ns / 1ps
module tb_rational_arith_reduce;
  import rar_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  logic         quiet_phase;
  logic         hold_off;

  rational_arith_reduce dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  tb_rar_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2000ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'(int'($urandom_range(0, 40)) - 20);
      4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      5: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // send one beat, optionally with a random gap before it
  task automatic send_beat(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, bd, bn, ad, an, op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // receiver side: random stall bursts and a long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    logic [1:0] op;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    quiet_phase = 1'b0;
    hold_off = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    for (int o = 0; o < 4; o++) begin
      send_beat(2'(o), 32'd1, 32'd2, 32'd1, 32'd3);
      send_beat(2'(o), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_beat(2'(o), 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'hffff_ffff);
    end
    send_beat(OP_MUL, 32'd0, 32'd0, 32'd5, 32'd7);
    send_beat(OP_ADD, 32'd0, 32'd4, 32'd0, 32'hffff_fffd);
    send_beat(OP_MUL, 32'd6, 32'd0, 32'hffff_fffe, 32'd0);
    send_beat(OP_DIV, 32'd3, 32'd5, 32'd0, 32'd7);
    send_beat(OP_SUB, 32'd2, 32'd3, 32'd2, 32'd3);
    send_beat(OP_MUL, 32'h7fff_ffff, 32'd1, 32'd2, 32'd1);
    send_beat(OP_DIV, 32'hffff_fffc, 32'd6, 32'd2, 32'hffff_fffd);
    send_beat(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // long receiver hold-off while the sender keeps offering
    hold_off <= 1'b1;
    fork
      begin
        repeat (3) send_beat(OP_ADD, pick_operand(), pick_operand(),
                             pick_operand(), pick_operand());
      end
      begin
        repeat (8000) @(posedge clk);
        hold_off <= 1'b0;
      end
    join

    // sender pauses until the block has drained
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (n = 0; n < 1730; n++) begin
      if (n == 1550) quiet_phase <= 1'b1;
      op = 2'($urandom_range(0, 3));
      send_beat(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
